// File: sv/ppct_pkg.sv
package ppct_pkg;

  localparam int unsigned PAD_W   = 4;
  localparam int unsigned VALUE_W = 7;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned CFG_W   = 16;

  // item kinds
  typedef enum logic [1:0] {
    KIND_X       = 2'd0,
    KIND_Y       = 2'd1,
    KIND_RELEASE = 2'd2
  } ppct_kind_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_RESEND_TIMEOUT = 2'd0,
    CFG_RESEND_STEP    = 2'd1,
    CFG_IGNORE_TIME    = 2'd2,
    CFG_RELEASE_VALUE  = 2'd3
  } ppct_cfg_idx_e;

  localparam logic [MS_W-1:0]    RESET_RESEND_TIMEOUT = 16'd100;
  localparam logic [VALUE_W-1:0] RESET_RESEND_STEP    = 7'd2;
  localparam logic [MS_W-1:0]    RESET_IGNORE_TIME    = 16'd10;
  localparam logic [VALUE_W-1:0] RESET_RELEASE_VALUE  = 7'd64;

  typedef struct packed {
    ppct_kind_e          kind;
    logic [PAD_W-1:0]    pad;
    logic [VALUE_W-1:0]  sample_value;
    logic [TIME_W-1:0]   now_ms;
  } ppct_in_t;

  typedef struct packed {
    logic                report;
    logic [VALUE_W-1:0]  report_value;
  } ppct_out_t;

  typedef struct packed {
    logic [MS_W-1:0]     resend_timeout_ms;
    logic [VALUE_W-1:0]  resend_step;
    logic [MS_W-1:0]     ignore_time_ms;
    logic [VALUE_W-1:0]  release_value;
  } ppct_cfg_t;

  // one table row per pad
  typedef struct packed {
    logic [VALUE_W-1:0]  x_value;
    logic [VALUE_W-1:0]  y_value;
    logic [TIME_W-1:0]   x_time;
    logic [TIME_W-1:0]   y_time;
  } ppct_row_t;

endpackage

// File: sv/ppct_mem.sv
module ppct_mem import ppct_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  ppct_row_t     wr_row_i,
  output ppct_row_t     rd_row_o
);

  ppct_row_t        mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  ppct_row_t        rdata_q;
  logic             rvld_q;
  logic             fwd_hit_q;
  ppct_row_t        fwd_row_q;

  // row storage, registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // per-row valid bits and forwarding of a write that meets a read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rvld_q    <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q    <= vld_q[rd_addr_i];
        fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_row_q <= wr_row_i;
    end
  end

  // never-written rows read as zero
  assign rd_row_o = fwd_hit_q ? fwd_row_q : (rvld_q ? rdata_q : '0);

endmodule

// File: sv/ppct_decide.sv
module ppct_decide import ppct_pkg::*; (
  input  ppct_in_t  item_i,
  input  logic      in_range_i,
  input  ppct_cfg_t cfg_i,
  input  ppct_row_t row_i,
  output ppct_out_t res_o,
  output logic      wr_en_o,
  output ppct_row_t wr_row_o
);

  logic [VALUE_W-1:0] prev;
  logic [TIME_W-1:0]  last_time;
  logic [TIME_W-1:0]  elapsed;
  logic [VALUE_W-1:0] diff;
  logic               timed_out;
  logic               send;
  logic [VALUE_W-1:0] new_value;

  // pick the axis entry
  always_comb begin
    if (item_i.kind == KIND_Y) begin
      prev      = row_i.y_value;
      last_time = row_i.y_time;
    end else begin
      prev      = row_i.x_value;
      last_time = row_i.x_time;
    end
  end

  // elapsed time and change size
  assign elapsed   = item_i.now_ms - last_time;
  assign diff      = (item_i.sample_value > prev) ? (item_i.sample_value - prev)
                                                  : (prev - item_i.sample_value);
  assign timed_out = elapsed > TIME_W'(cfg_i.resend_timeout_ms);
  assign send      = timed_out ? (diff > cfg_i.resend_step)
                               : ((item_i.sample_value != prev) &&
                                  (elapsed > TIME_W'(cfg_i.ignore_time_ms)));
  assign new_value = send ? item_i.sample_value : prev;

  // result and row update
  always_comb begin
    res_o    = '0;
    wr_en_o  = 1'b0;
    wr_row_o = row_i;
    if (in_range_i) begin
      unique case (item_i.kind)
        KIND_X: begin
          res_o.report       = send;
          res_o.report_value = new_value;
          wr_en_o            = send;
          wr_row_o.x_value   = item_i.sample_value;
          wr_row_o.x_time    = item_i.now_ms;
        end
        KIND_Y: begin
          res_o.report       = send;
          res_o.report_value = new_value;
          wr_en_o            = send;
          wr_row_o.y_value   = item_i.sample_value;
          wr_row_o.y_time    = item_i.now_ms;
        end
        KIND_RELEASE: begin
          res_o.report_value = cfg_i.release_value;
          wr_en_o            = 1'b1;
          wr_row_o.x_value   = cfg_i.release_value;
          wr_row_o.y_value   = cfg_i.release_value;
        end
        default: begin
          res_o   = '0;
          wr_en_o = 1'b0;
        end
      endcase
    end
  end

endmodule

// File: sv/pad_position_change_throttle.sv
// Touch pad position change throttle.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one word per item:
// an X or Y sample or a pad release, with the pad index and the ms time.
// Output channel (out_valid_o/out_ready_i/out_data_o) gives one word per
// item: the report flag and the stored axis value after the update.
// Per-pad state sits in one table row (both values and both report times),
// read at accept, updated in the read stage and written back; a write that
// meets a read of the same pad is forwarded.
// The result word passes the read stage register, then the output register.
// Throughput: 1 item per cycle while the receiver takes words; the table
// read-modify-write sets this figure. When the receiver stalls, the result
// word is held in the output register, one more item is read and held
// behind it, then in_ready_o drops. Reset clears all rows to zero through
// valid bits (no clearing pass) and loads the default register values.
// Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once and
// are to be made by the user while the block is idle; it does not check.
module pad_position_change_throttle import ppct_pkg::*; #(
  parameter int unsigned PAD_COUNT = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ppct_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ppct_out_t            out_data_o,
  input  logic                 cfg_we_i,
  input  ppct_cfg_idx_e        cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned PadAw   = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam int unsigned PadExtW = (PadAw > PAD_W) ? PadAw : PAD_W;

  ppct_cfg_t        cfg_q;
  logic             s1_valid_q;
  ppct_in_t         s1_item_q;
  logic             s1_range_q;
  logic             out_valid_q;
  logic             out_valid_d;
  ppct_out_t        out_data_q;

  logic             accept;
  logic             s1_adv;
  logic             in_range;
  logic [PadExtW-1:0] in_pad_ext;
  logic [PadExtW-1:0] s1_pad_ext;
  ppct_row_t        rd_row;
  ppct_out_t        dec_res;
  logic             dec_we;
  ppct_row_t        dec_row;
  logic             mem_we;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.resend_timeout_ms <= RESET_RESEND_TIMEOUT;
      cfg_q.resend_step       <= RESET_RESEND_STEP;
      cfg_q.ignore_time_ms    <= RESET_IGNORE_TIME;
      cfg_q.release_value     <= RESET_RELEASE_VALUE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RESEND_TIMEOUT: cfg_q.resend_timeout_ms <= cfg_wdata_i[MS_W-1:0];
        CFG_RESEND_STEP:    cfg_q.resend_step       <= cfg_wdata_i[VALUE_W-1:0];
        CFG_IGNORE_TIME:    cfg_q.ignore_time_ms    <= cfg_wdata_i[MS_W-1:0];
        CFG_RELEASE_VALUE:  cfg_q.release_value     <= cfg_wdata_i[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  assign in_pad_ext = PadExtW'(in_data_i.pad);
  assign s1_pad_ext = PadExtW'(s1_item_q.pad);
  assign in_range   = 32'(in_data_i.pad) < 32'(PAD_COUNT);

  // read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q  <= in_data_i;
      s1_range_q <= in_range;
    end
  end

  assign mem_we = s1_adv && dec_we;

  ppct_mem #(
    .DEPTH (PAD_COUNT),
    .AW    (PadAw)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && in_range),
    .rd_addr_i (in_pad_ext[PadAw-1:0]),
    .wr_en_i   (mem_we),
    .wr_addr_i (s1_pad_ext[PadAw-1:0]),
    .wr_row_i  (dec_row),
    .rd_row_o  (rd_row)
  );

  ppct_decide u_decide (
    .item_i     (s1_item_q),
    .in_range_i (s1_range_q),
    .cfg_i      (cfg_q),
    .row_i      (rd_row),
    .res_o      (dec_res),
    .wr_en_o    (dec_we),
    .wr_row_o   (dec_row)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= dec_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  // a held item is not lost while the output is blocked
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("read stage item dropped while stalled");

  // table is written only when an item moves to the output
  a_we_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (s1_valid_q && s1_range_q))
    else $error("table write without a valid in-range item");

  // release never reports and returns the release value
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_range_q && (s1_item_q.kind == KIND_RELEASE)) |=>
    (!out_data_o.report && (out_data_o.report_value == $past(cfg_q.release_value))))
    else $error("release result wrong");

  // out-of-range pad gives an empty result
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_range_q) |=> (out_data_o == '0))
    else $error("out-of-range pad produced a result");

  // an empty read stage always takes input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input blocked with empty read stage");
`endif

endmodule

// File: tb/pad_position_change_throttle_test.sv
module pad_position_change_throttle_test;
  import ppct_pkg::*;

  // kind code that the block must treat as a no-op
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam int unsigned PAD_SLOTS = 16;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ppct_in_t            in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ppct_out_t           out_word;
  logic                cfg_we = 1'b0;
  ppct_cfg_idx_e       cfg_idx = CFG_RESEND_TIMEOUT;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  pad_position_change_throttle #(
    .PAD_COUNT(PAD_SLOTS)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // shadow of the per-pad table and the registers
  logic [VALUE_W-1:0] x_value [PAD_SLOTS];
  logic [VALUE_W-1:0] y_value [PAD_SLOTS];
  logic [TIME_W-1:0]  x_time  [PAD_SLOTS];
  logic [TIME_W-1:0]  y_time  [PAD_SLOTS];
  ppct_cfg_t          throttle_cfg;

  ppct_in_t  pad_events[$];
  ppct_out_t awaited_reports[$];
  int        mismatch_count = 0;

  int        send_gap = 0;
  int        send_calm = 0;
  int        recv_stall = 0;
  int        recv_calm = 0;
  int        words_taken = 0;
  bit        long_hold_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // throttle decision for one event, updates the shadow table
  function automatic ppct_out_t throttle_decision(ppct_in_t ev);
    ppct_out_t          res;
    logic [VALUE_W-1:0] prev;
    logic [TIME_W-1:0]  stamp;
    logic [TIME_W-1:0]  elapsed;
    logic [VALUE_W-1:0] delta;
    logic               send;
    res = '0;
    case (ev.kind)
      KIND_X, KIND_Y: begin
        prev    = (ev.kind == KIND_X) ? x_value[ev.pad] : y_value[ev.pad];
        stamp   = (ev.kind == KIND_X) ? x_time[ev.pad] : y_time[ev.pad];
        elapsed = ev.now_ms - stamp;
        delta   = (ev.sample_value > prev) ? ev.sample_value - prev
                                           : prev - ev.sample_value;
        if (elapsed > TIME_W'(throttle_cfg.resend_timeout_ms)) begin
          send = delta > throttle_cfg.resend_step;
        end else begin
          send = (ev.sample_value != prev) &&
                 (elapsed > TIME_W'(throttle_cfg.ignore_time_ms));
        end
        if (send) begin
          prev = ev.sample_value;
          if (ev.kind == KIND_X) begin
            x_value[ev.pad] = prev;
            x_time[ev.pad]  = ev.now_ms;
          end else begin
            y_value[ev.pad] = prev;
            y_time[ev.pad]  = ev.now_ms;
          end
        end
        res.report       = send;
        res.report_value = prev;
      end
      KIND_RELEASE: begin
        x_value[ev.pad]  = throttle_cfg.release_value;
        y_value[ev.pad]  = throttle_cfg.release_value;
        res.report_value = throttle_cfg.release_value;
      end
      default: ;
    endcase
    return res;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int draw_gap(input int idle_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r >= idle_pct) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  task automatic queue_event(input logic [1:0] kind, input int pad, input int value,
                             input logic [TIME_W-1:0] now);
    ppct_in_t ev;
    ev.kind         = ppct_kind_e'(kind);
    ev.pad          = PAD_W'(pad);
    ev.sample_value = VALUE_W'(value);
    ev.now_ms       = now;
    pad_events.push_back(ev);
  endtask

  // all four registers, then the shadow copy
  task automatic apply_settings(input logic [MS_W-1:0] timeout_ms,
                                input logic [VALUE_W-1:0] min_step,
                                input logic [MS_W-1:0] hold_ms,
                                input logic [VALUE_W-1:0] rel_value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_RESEND_TIMEOUT;
    cfg_wdata <= timeout_ms;
    @(posedge clk);
    cfg_idx   <= CFG_RESEND_STEP;
    cfg_wdata <= CFG_W'(min_step);
    @(posedge clk);
    cfg_idx   <= CFG_IGNORE_TIME;
    cfg_wdata <= hold_ms;
    @(posedge clk);
    cfg_idx   <= CFG_RELEASE_VALUE;
    cfg_wdata <= CFG_W'(rel_value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    throttle_cfg.resend_timeout_ms = timeout_ms;
    throttle_cfg.resend_step       = min_step;
    throttle_cfg.ignore_time_ms    = hold_ms;
    throttle_cfg.release_value     = rel_value;
  endtask

  // wait until every event is taken and every word is back
  task automatic drain_pipeline();
    while (pad_events.size() != 0 || awaited_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [MS_W-1:0] pick_ms();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return MS_W'($urandom_range(5, 150));
      4: return MS_W'($urandom_range(0, 65535));
      default: return MS_W'($urandom_range(150, 400));
    endcase
  endfunction

  // sender: one event per handshake, random gaps between events
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_reports.push_back(throttle_decision(in_word));
        void'(pad_events.pop_front());
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(15, 50);
          send_gap = draw_gap(35);
        end
      end
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pad_events.size() > 0) begin
          in_valid <= 1'b1;
          in_word  <= pad_events[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each word, random stalls and one long hold-off
  always @(posedge clk) begin
    ppct_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_taken++;
        if (awaited_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word, got report %0b value %0d",
                   $time, out_word.report, out_word.report_value);
        end else begin
          want = awaited_reports.pop_front();
          if (want.report !== out_word.report) begin
            mismatch_count++;
            $display("%0t: report flag, expected %0b got %0b",
                     $time, want.report, out_word.report);
          end
          if (want.report_value !== out_word.report_value) begin
            mismatch_count++;
            $display("%0t: report value, expected %0d got %0d",
                     $time, want.report_value, out_word.report_value);
          end
        end
      end
      // back up the block while the sender keeps offering
      if (!long_hold_done && words_taken >= 300 && in_valid) begin
        long_hold_done = 1'b1;
        recv_stall     = 80;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm--;
        end else begin
          if ($urandom_range(0, 99) == 0) recv_calm = $urandom_range(20, 60);
          recv_stall = draw_gap(10);
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [TIME_W-1:0]  clock_ms;
    logic [1:0]         kind;
    logic [VALUE_W-1:0] recent_value [2*PAD_SLOTS];
    int                 pad;
    int                 value;
    int                 pick;
    int                 slot;
    throttle_cfg.resend_timeout_ms = RESET_RESEND_TIMEOUT;
    throttle_cfg.resend_step       = RESET_RESEND_STEP;
    throttle_cfg.ignore_time_ms    = RESET_IGNORE_TIME;
    throttle_cfg.release_value     = RESET_RELEASE_VALUE;
    for (int i = 0; i < PAD_SLOTS; i++) begin
      x_value[i] = '0;
      y_value[i] = '0;
      x_time[i]  = '0;
      y_time[i]  = '0;
    end
    for (int i = 0; i < 2 * PAD_SLOTS; i++) recent_value[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: wrapped elapsed time, ignore and timeout borders
    queue_event(KIND_X, 0, 127, 32'hFFFF_FFFF);
    queue_event(KIND_X, 0, 126, 32'h0000_0004);
    queue_event(KIND_X, 0, 126, 32'h0000_0009);
    queue_event(KIND_X, 0, 126, 32'h0000_000A);
    queue_event(KIND_X, 0, 126, 32'h0000_00C8);
    queue_event(KIND_Y, 15, 2, 32'd100);
    queue_event(KIND_Y, 15, 4, 32'd201);
    queue_event(KIND_Y, 15, 5, 32'd201);
    queue_event(KIND_RELEASE, 15, 127, 32'h5555_5555);
    queue_event(KIND_Y, 15, 64, 32'hAAAA_AAAA);
    queue_event(KIND_X, 15, 0, 32'hAAAA_AAAA);
    queue_event(KIND_UNKNOWN, 10, 85, 32'h5555_5555);
    queue_event(KIND_X, 5, 42, 32'h0000_0000);
    queue_event(KIND_Y, 10, 85, 32'h0000_FFFF);
    drain_pipeline();

    // all registers at zero
    apply_settings('0, '0, '0, '0);
    queue_event(KIND_RELEASE, 3, 0, 32'd50);
    queue_event(KIND_X, 3, 0, 32'd50);
    queue_event(KIND_X, 3, 1, 32'd50);
    queue_event(KIND_X, 3, 2, 32'd50);
    queue_event(KIND_Y, 3, 0, 32'd51);
    drain_pipeline();

    // all registers at their maximum
    apply_settings('1, '1, '1, '1);
    queue_event(KIND_RELEASE, 6, 0, 32'd7);
    queue_event(KIND_X, 6, 0, 32'h0002_0000);
    queue_event(KIND_Y, 6, 126, 32'h0002_0000);
    queue_event(KIND_X, 9, 127, 32'h0000_0000);
    drain_pipeline();

    // random phases, each with its own settings
    clock_ms = $urandom;
    for (int phase = 0; phase < 6; phase++) begin
      apply_settings(pick_ms(),
                     ($urandom_range(0, 5) == 0) ? VALUE_W'($urandom_range(0, 127))
                                                 : VALUE_W'($urandom_range(0, 5)),
                     pick_ms(), VALUE_W'($urandom_range(0, 127)));
      if ($urandom_range(0, 2) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 46) kind = KIND_X;
        else if (pick < 92) kind = KIND_Y;
        else if (pick < 98) kind = KIND_RELEASE;
        else kind = KIND_UNKNOWN;
        pad  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 15);
        slot = 2 * pad + kind[0];
        if ($urandom_range(0, 9) < 6) begin
          value = int'(recent_value[slot]) + $urandom_range(0, 8) - 4;
          if (value < 0) value = 0;
          if (value > 127) value = 127;
        end else begin
          value = $urandom_range(0, 127);
        end
        recent_value[slot] = VALUE_W'(value);
        // time moves on by a mostly small, sometimes large amount
        pick = $urandom_range(0, 99);
        if (pick < 50) clock_ms += $urandom_range(0, 15);
        else if (pick < 80) clock_ms += $urandom_range(10, 120);
        else if (pick < 95) clock_ms += $urandom_range(90, 400);
        else if (pick < 99) clock_ms += $urandom_range(1000, 70000);
        else clock_ms = $urandom;
        queue_event(kind, pad, value, clock_ms);
      end
      drain_pipeline();
    end

    if (mismatch_count == 0) begin
      $display("pad_position_change_throttle regression: pass");
    end else begin
      $display("pad_position_change_throttle regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("pad_position_change_throttle regression: fail");
    $finish;
  end

endmodule
